// ===== rtl/json_string_unescape_utf8_top_macros.svh =====
// ----------------------------------------------------------------------------
// JSON string unescape assertion macros
// Shared same-cycle and next-cycle implication assertion forms for checkers.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result kinds, error codes, surrogate bounds and the command passed from
// the decoder to the UTF-8 encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_NO_OPEN    = 4'd1;
  localparam logic [3:0] ERR_UNTERM     = 4'd2;
  localparam logic [3:0] ERR_UNTERM_ESC = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC    = 4'd4;
  localparam logic [3:0] ERR_CTRL       = 4'd5;
  localparam logic [3:0] ERR_TRUNC_U    = 4'd6;
  localparam logic [3:0] ERR_BAD_HEX    = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW    = 4'd8;
  localparam logic [3:0] ERR_UNP_HIGH   = 4'd9;
  localparam logic [3:0] ERR_UNP_LOW    = 4'd10;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  // A raw command gives one result carrying cp[7:0]; otherwise cp is
  // encoded as one to four UTF-8 data bytes.
  typedef struct packed {
    logic        raw;
    logic [1:0]  kind;
    logic [3:0]  code;
    logic [20:0] cp;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Tracks the string and escape state for each accepted byte and issues at
// most one command per byte.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      text_byte_i,
  input  wire logic            func_i,
  output jsu_pkg::cmd_t        cmd_o,
  output logic                 cmd_valid_o
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_STR   = 4'd1;
  localparam logic [3:0] PH_ESC   = 4'd2;
  localparam logic [3:0] PH_HEX1  = 4'd3;
  localparam logic [3:0] PH_HEX2  = 4'd4;
  localparam logic [3:0] PH_HEX3  = 4'd5;
  localparam logic [3:0] PH_HEX4  = 4'd6;
  localparam logic [3:0] PH_BS    = 4'd7;
  localparam logic [3:0] PH_U     = 4'd8;
  localparam logic [3:0] PH_LHEX1 = 4'd9;
  localparam logic [3:0] PH_LHEX2 = 4'd10;
  localparam logic [3:0] PH_LHEX3 = 4'd11;
  localparam logic [3:0] PH_LHEX4 = 4'd12;

  logic [3:0]  phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [9:0]  high_q, high_d;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] hex_new;

  function automatic jsu_pkg::cmd_t single(input logic [1:0] kind, input logic [3:0] code,
                                           input logic [7:0] data);
    jsu_pkg::cmd_t c;
    c.raw  = 1'b1;
    c.kind = kind;
    c.code = code;
    c.cp   = {13'd0, data};
    return c;
  endfunction

  function automatic jsu_pkg::cmd_t encode(input logic [20:0] cp);
    jsu_pkg::cmd_t c;
    c.raw  = 1'b0;
    c.kind = jsu_pkg::KIND_DATA;
    c.code = jsu_pkg::ERR_NONE;
    c.cp   = cp;
    return c;
  endfunction

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (text_byte_i >= "0" && text_byte_i <= "9") begin
      hex_val = 4'(text_byte_i - "0");
    end else if (text_byte_i >= "a" && text_byte_i <= "f") begin
      hex_val = 4'(text_byte_i - "a" + 8'd10);
    end else if (text_byte_i >= "A" && text_byte_i <= "F") begin
      hex_val = 4'(text_byte_i - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign hex_new = {hex_q[11:0], hex_val};

  always_comb begin
    phase_d     = phase_q;
    hex_d       = hex_q;
    high_d      = high_q;
    cmd_valid_o = 1'b0;
    cmd_o       = '0;
    if (accept_i) begin
      case (phase_q)
        PH_STR: begin
          if (func_i) begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM, 8'd0);
            phase_d     = PH_IDLE;
          end else if (text_byte_i == "\"") begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_DONE, jsu_pkg::ERR_NONE, 8'd0);
            phase_d     = PH_IDLE;
          end else if (text_byte_i == "\\") begin
            phase_d = PH_ESC;
          end else if (text_byte_i < jsu_pkg::CTRL_LIMIT) begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_CTRL, 8'd0);
            phase_d     = PH_IDLE;
          end else begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, text_byte_i);
          end
        end
        PH_ESC: begin
          cmd_valid_o = 1'b1;
          phase_d     = PH_STR;
          if (func_i) begin
            cmd_o   = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNTERM_ESC, 8'd0);
            phase_d = PH_IDLE;
          end else begin
            case (text_byte_i)
              "\"", "\\", "/": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE,
                                              text_byte_i);
              "b": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h08);
              "f": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0C);
              "n": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0A);
              "r": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h0D);
              "t": cmd_o = single(jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE, 8'h09);
              "u": begin
                cmd_valid_o = 1'b0;
                phase_d     = PH_HEX1;
                hex_d       = 16'd0;
              end
              default: begin
                cmd_o   = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_ESC, 8'd0);
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        PH_BS: begin
          if (func_i || text_byte_i != "\\") begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNP_HIGH, 8'd0);
            phase_d     = PH_IDLE;
          end else begin
            phase_d = PH_U;
          end
        end
        PH_U: begin
          if (func_i || text_byte_i != "u") begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNP_HIGH, 8'd0);
            phase_d     = PH_IDLE;
          end else begin
            phase_d = PH_LHEX1;
            hex_d   = 16'd0;
          end
        end
        PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4,
        PH_LHEX1, PH_LHEX2, PH_LHEX3, PH_LHEX4: begin
          if (func_i) begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_TRUNC_U, 8'd0);
            phase_d     = PH_IDLE;
          end else if (!hex_ok) begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_HEX, 8'd0);
            phase_d     = PH_IDLE;
          end else begin
            hex_d = hex_new;
            if (phase_q == PH_HEX4) begin
              if (hex_new >= jsu_pkg::HIGH_MIN && hex_new <= jsu_pkg::HIGH_MAX) begin
                high_d  = hex_new[9:0];
                phase_d = PH_BS;
              end else if (hex_new >= jsu_pkg::LOW_MIN && hex_new <= jsu_pkg::LOW_MAX) begin
                cmd_valid_o = 1'b1;
                cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_UNP_LOW, 8'd0);
                phase_d     = PH_IDLE;
              end else begin
                cmd_valid_o = 1'b1;
                cmd_o       = encode({5'd0, hex_new});
                phase_d     = PH_STR;
              end
            end else if (phase_q == PH_LHEX4) begin
              cmd_valid_o = 1'b1;
              if (hex_new < jsu_pkg::LOW_MIN || hex_new > jsu_pkg::LOW_MAX) begin
                cmd_o   = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_BAD_LOW, 8'd0);
                phase_d = PH_IDLE;
              end else begin
                cmd_o   = encode(jsu_pkg::SUPP_BASE + {1'b0, high_q, hex_new[9:0]});
                phase_d = PH_STR;
              end
            end else begin
              phase_d = phase_q + 4'd1;
            end
          end
        end
        default: begin
          if (func_i || text_byte_i != "\"") begin
            cmd_valid_o = 1'b1;
            cmd_o       = single(jsu_pkg::KIND_ERROR, jsu_pkg::ERR_NO_OPEN, 8'd0);
            phase_d     = PH_IDLE;
          end else begin
            phase_d = PH_STR;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q   <= 16'd0;
      high_q  <= 10'd0;
    end else begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      high_q  <= high_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape command queue
// Small register queue that decouples the decoder from the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire jsu_pkg::cmd_t  cmd_i,
  input  wire logic           pop_i,
  output jsu_pkg::cmd_t       cmd_o,
  output logic                full_o,
  output logic                empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_pkg::cmd_t mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wrap_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= wrap_inc(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape encoder
// Expands each command into its result bytes and holds them in an output
// register until they are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire jsu_pkg::cmd_t cmd_i,
  input  wire logic        cmd_empty_i,
  output logic             cmd_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [7:0]       out_byte_o,
  output logic [1:0]       kind_o,
  output logic [3:0]       error_code_o,
  output logic             last_o
);

  logic [1:0] idx_q;
  logic [1:0] last_idx;
  logic [7:0] bytes [4];
  logic       valid_q;
  logic       load;
  logic       final_byte;
  logic [7:0] byte_q;
  logic [1:0] kind_q;
  logic [3:0] code_q;
  logic       last_q;

  always_comb begin
    bytes[0] = cmd_i.cp[7:0];
    bytes[1] = 8'd0;
    bytes[2] = 8'd0;
    bytes[3] = 8'd0;
    last_idx = 2'd0;
    if (!cmd_i.raw) begin
      if (cmd_i.cp < 21'h80) begin
        last_idx = 2'd0;
      end else if (cmd_i.cp < 21'h800) begin
        last_idx = 2'd1;
        bytes[0] = jsu_pkg::LEAD2_MARK | {3'd0, cmd_i.cp[10:6]};
        bytes[1] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[5:0]};
      end else if (cmd_i.cp < 21'h10000) begin
        last_idx = 2'd2;
        bytes[0] = jsu_pkg::LEAD3_MARK | {4'd0, cmd_i.cp[15:12]};
        bytes[1] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[11:6]};
        bytes[2] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[5:0]};
      end else begin
        last_idx = 2'd3;
        bytes[0] = jsu_pkg::LEAD4_MARK | {5'd0, cmd_i.cp[20:18]};
        bytes[1] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[17:12]};
        bytes[2] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[11:6]};
        bytes[3] = jsu_pkg::CONT_MARK | {2'd0, cmd_i.cp[5:0]};
      end
    end
  end

  assign load       = !cmd_empty_i && (!valid_q || pop_i);
  assign final_byte = (idx_q == last_idx);
  assign cmd_pop_o  = load && final_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= final_byte ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= bytes[idx_q];
      kind_q <= cmd_i.kind;
      code_q <= cmd_i.code;
      last_q <= final_byte;
    end
  end

  assign empty_o      = !valid_q;
  assign out_byte_o   = byte_q;
  assign kind_o       = kind_q;
  assign error_code_o = code_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8_top.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Decodes the bytes of JSON string literals into UTF-8 bytes, done markers
// and numbered error results.
// ----------------------------------------------------------------------------
// Usage: text bytes enter through push/full; func_i high marks the end of
// the text. Results leave through empty/pop, oldest first, with last_o on
// the final result of each input request.
// A request is accepted every cycle while full is low. Its first result passes
// through the command queue and the output register before it is on the
// ports, and results drain at one per cycle while pop is high; a \u escape
// yields up to four bytes, which the encoder issues one after another.
// The decoder issues at most one command per request into a queue of
// QUEUE_DEPTH entries; while the receiver stalls, the queue fills and
// full rises. Reset returns the decoder to waiting for an opening quote and
// empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] text_byte_i,
  input  wire logic       func_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic [3:0]      error_code_o,
  output logic            last_o
);

  jsu_pkg::cmd_t front_cmd;
  jsu_pkg::cmd_t head_cmd;
  logic          front_valid;
  logic          q_empty;
  logic          q_pop;
  logic          accept;

  assign accept = push && !full;

  jsu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .text_byte_i (text_byte_i),
    .func_i      (func_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid)
  );

  jsu_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .full_o  (full),
    .empty_o (q_empty)
  );

  jsu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (head_cmd),
    .cmd_empty_i  (q_empty),
    .cmd_pop_o    (q_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_byte_o   (out_byte_o),
    .kind_o       (kind_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== rtl/jsu_checker.sv =====
// ----------------------------------------------------------------------------
// JSON string unescape checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "json_string_unescape_utf8_top_macros.svh"

module jsu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] out_byte_o,
  input wire logic [1:0] kind_o,
  input wire logic [3:0] error_code_o,
  input wire logic       last_o
);

  logic        res_mark;
  logic        res_err;
  logic        res_clean;
  logic        code_ok;
  logic        clean_ok;
  logic [14:0] res_word;

  assign res_mark  = !empty && (kind_o != jsu_pkg::KIND_DATA);
  assign res_err   = !empty && (kind_o == jsu_pkg::KIND_ERROR);
  assign res_clean = !empty && (kind_o != jsu_pkg::KIND_ERROR);
  assign code_ok   = (error_code_o != jsu_pkg::ERR_NONE) &&
                     (error_code_o <= jsu_pkg::ERR_UNP_LOW);
  assign clean_ok  = (error_code_o == jsu_pkg::ERR_NONE) &&
                     (kind_o <= jsu_pkg::KIND_DONE);
  assign res_word  = {out_byte_o, kind_o, error_code_o, last_o};

  `JSU_ASSERT_NOW(a_marker_is_last, res_mark, last_o)
  `JSU_ASSERT_NOW(a_error_has_code, res_err, code_ok)
  `JSU_ASSERT_NOW(a_non_error_clean, res_clean, clean_ok)
  `JSU_ASSERT_NEXT(a_stall_holds, !empty && !pop, !empty && $stable(res_word))
  `JSU_ASSERT_NOW(a_full_has_result, full, !empty)

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (.*);

`default_nettype wire
